### design/upfcf_pkg.sv
package upfcf_pkg;

   // Input transaction: one frame byte plus end-of-frame marker
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   // Result transaction: one verdict per frame
   typedef struct packed {
      logic        capture;
      logic [12:0] capture_length;
      logic [15:0] frame_length;
   } rsp_type;

   // Per-frame header fields latched while the frame streams in
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      logic [15:0] fragment_field;
      logic [7:0]  ip_protocol;
      logic [15:0] dest_port;
   } fields_type;

   // Control/status register indexes
   localparam logic [1:0] CSR_TARGET_PORT   = 2'd0;
   localparam logic [1:0] CSR_CAPTURE_LIMIT = 2'd1;

   localparam logic [15:0] TARGET_PORT_RESET   = 16'd52719;
   localparam logic [12:0] CAPTURE_LIMIT_RESET = 13'd2048;
   localparam logic [12:0] LIMIT_MAX           = 13'd4096;

   // Frame byte offsets
   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_IHL      = 16'd14;
   localparam logic [15:0] POS_FRAG_HI  = 16'd20;
   localparam logic [15:0] POS_FRAG_LO  = 16'd21;
   localparam logic [15:0] POS_PROTO    = 16'd23;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] MIN_FRAME      = 16'd34;
   localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
   localparam logic [7:0]  UDP_PROTO      = 8'd17;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   // Port offset 14+4*IHL+2 and UDP header end 14+4*IHL+8
   localparam logic [6:0]  PORT_BASE    = 7'd16;
   localparam logic [6:0]  UDP_END_BASE = 7'd22;

endpackage

### design/udp_port_fragment_capture_filter.sv
// Frame filter for IPv4/UDP: takes one Ethernet frame byte per transaction,
// starting at the destination MAC, and returns one verdict transaction per
// frame on the byte marked last. A frame is captured when it is IPv4, at
// least 34 bytes long, and is either an IP fragment or UDP to target_port
// with the whole UDP header inside the frame; anything else passes. It
// accepts one byte every cycle unless stalled: a byte goes into the input
// register, then the field update and verdict logic write the verdict into
// the result register as the last byte leaves the input register. The input
// stalls only when a verdict is pending in the result register and the
// next verdict needs it. Registers: index 0 target_port, index 1
// capture_limit (above 4096 acts as 4096); write them only while idle.
module udp_port_fragment_capture_filter
   import upfcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   // verdict output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [15:0] target_port_ff;
   logic [12:0] capture_limit_ff;
   logic        advance;
   fields_type  nf;
   logic [6:0]  udp_end;
   logic        is_ipv4;
   logic        frag_hit;
   logic        port_hit;
   logic        cap;
   logic [12:0] limit;

   // Register writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_port_ff   <= TARGET_PORT_RESET;
         capture_limit_ff <= CAPTURE_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_PORT:   target_port_ff   <= csr_data;
            CSR_CAPTURE_LIMIT: capture_limit_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: a non-last byte never needs the result register
   assign advance   = in_valid_ff && (!in_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   // Header field capture
   upfcf_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_byte  (in_ff.frame_byte),
      .last_byte   (in_ff.last_byte),
      .next_fields (nf)
   );

   // Verdict
   always_comb begin
      udp_end     = UDP_END_BASE + {1'b0, nf.header_words, 2'b00};
      is_ipv4     = (nf.byte_count >= MIN_FRAME) && (nf.ether_type == ETHERTYPE_IPV4);
      frag_hit    = (nf.fragment_field & FRAG_MASK) != 16'd0;
      port_hit    = (nf.ip_protocol == UDP_PROTO)
                    && (nf.byte_count >= {9'd0, udp_end})
                    && (nf.dest_port == target_port_ff);
      cap         = is_ipv4 && (frag_hit || port_hit);
      limit       = (capture_limit_ff > LIMIT_MAX) ? LIMIT_MAX : capture_limit_ff;
      rsp_in.capture        = cap;
      rsp_in.frame_length   = nf.byte_count;
      rsp_in.capture_length = '0;
      if (cap) begin
         rsp_in.capture_length = (nf.byte_count > {3'd0, limit}) ? limit
                                                                 : nf.byte_count[12:0];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A verdict shows up only after a last byte went through
   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_ff.last_byte))
      else $error("verdict without end of frame");

   // A passed frame reports no capture length
   a_pass_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.capture |-> rsp_ff.capture_length == 13'd0)
      else $error("pass verdict with nonzero capture length");

   // Capture length never exceeds the frame length
   a_cap_le_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> {3'd0, rsp_ff.capture_length} <= rsp_ff.frame_length)
      else $error("capture length above frame length");

   // A held byte is not lost while the result side stalls
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held byte dropped");

endmodule

### design/upfcf_parse.sv
// Header field capture: tracks byte position and latches the fields of
// interest. next_fields shows the values after the current byte, before
// the end-of-frame clear.
module upfcf_parse
   import upfcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] frame_byte,
   input  logic       last_byte,
   output fields_type next_fields
);

   fields_type fields_ff;
   fields_type fields_in;
   fields_type upd;
   logic [6:0] port_at;

   // Field updates for the byte at the current position
   always_comb begin
      upd     = fields_ff;
      port_at = PORT_BASE + {1'b0, fields_ff.header_words, 2'b00};
      unique case (fields_ff.byte_count)
         POS_ETYPE_HI: upd.ether_type[15:8]     = frame_byte;
         POS_ETYPE_LO: upd.ether_type[7:0]      = frame_byte;
         POS_IHL:      upd.header_words         = frame_byte[3:0];
         POS_FRAG_HI:  upd.fragment_field[15:8] = frame_byte;
         POS_FRAG_LO:  upd.fragment_field[7:0]  = frame_byte;
         POS_PROTO:    upd.ip_protocol          = frame_byte;
         default: ;
      endcase
      // UDP destination port, big-endian
      if (fields_ff.byte_count == {9'd0, port_at}) begin
         upd.dest_port[15:8] = frame_byte;
      end else if (fields_ff.byte_count == {9'd0, port_at + 7'd1}) begin
         upd.dest_port[7:0] = frame_byte;
      end
      // saturating byte count
      if (fields_ff.byte_count != COUNT_MAX) begin
         upd.byte_count = fields_ff.byte_count + 16'd1;
      end
   end

   assign next_fields = upd;

   // clear everything after the verdict byte
   always_comb begin
      fields_in = fields_ff;
      if (step) begin
         fields_in = last_byte ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff <= '0;
      end else begin
         fields_ff <= fields_in;
      end
   end

endmodule

### bench/tb_udp_port_fragment_capture_filter.sv
module tb_udp_port_fragment_capture_filter;
   import upfcf_pkg::*;

   // Indexes outside the register map, written once to show they are ignored
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam int CYCLE_LIMIT = 1500000;

   typedef enum int {
      FR_UDP_HIT,
      FR_UDP_MISS,
      FR_FRAGMENT,
      FR_NON_IPV4,
      FR_SHORT,
      FR_SHORT_UDP,
      FR_SMALL_IHL,
      FR_NOISE
   } frame_kind_type;

   // Verdict predictor and store of expected verdicts
   class verdict_board;
      logic [15:0] port_sel;
      logic [12:0] limit_sel;
      logic [15:0] nbytes;
      logic [15:0] etype;
      logic [3:0]  ihl;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [15:0] dport;
      rsp_type     verdicts[$];
      int          errors;

      function new();
         port_sel  = TARGET_PORT_RESET;
         limit_sel = CAPTURE_LIMIT_RESET;
         errors    = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         nbytes = '0;
         etype  = '0;
         ihl    = '0;
         frag   = '0;
         proto  = '0;
         dport  = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_TARGET_PORT:   port_sel = data;
            CSR_CAPTURE_LIMIT: limit_sel = data[12:0];
            default: ;
         endcase
      endfunction

      // Latch header fields from one accepted byte; on the last byte, queue a verdict
      function void note_byte(req_type item);
         logic [15:0] pos;
         logic [7:0]  b;
         logic [12:0] lim;
         int unsigned port_at;
         int unsigned udp_end;
         bit          cap;
         rsp_type     v;
         pos     = nbytes;
         b       = item.frame_byte;
         port_at = PORT_BASE + 4 * ihl;
         case (pos)
            POS_ETYPE_HI: etype[15:8] = b;
            POS_ETYPE_LO: etype[7:0]  = b;
            POS_IHL:      ihl         = b[3:0];
            POS_FRAG_HI:  frag[15:8]  = b;
            POS_FRAG_LO:  frag[7:0]   = b;
            POS_PROTO:    proto       = b;
            default: ;
         endcase
         if (pos == port_at) begin
            dport[15:8] = b;
         end else if (pos == port_at + 1) begin
            dport[7:0] = b;
         end
         if (nbytes != COUNT_MAX) begin
            nbytes = nbytes + 16'd1;
         end
         if (!item.last_byte) begin
            return;
         end
         udp_end = UDP_END_BASE + 4 * ihl;
         cap = 1'b0;
         if (nbytes >= MIN_FRAME && etype == ETHERTYPE_IPV4) begin
            if ((frag & FRAG_MASK) != 16'd0) begin
               cap = 1'b1;
            end else if (proto == UDP_PROTO && nbytes >= udp_end && dport == port_sel) begin
               cap = 1'b1;
            end
         end
         lim = (limit_sel > LIMIT_MAX) ? LIMIT_MAX : limit_sel;
         v.capture        = cap;
         v.capture_length = cap ? ((nbytes > lim) ? lim : nbytes[12:0]) : 13'd0;
         v.frame_length   = nbytes;
         verdicts.push_back(v);
         clear_frame();
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual cap %0d len %0d frame %0d",
                     $time, got.capture, got.capture_length, got.frame_length);
            errors++;
            return;
         end
         want = verdicts.pop_front();
         if (got.capture !== want.capture) begin
            $display("%0t: capture mismatch, expected %0d actual %0d",
                     $time, want.capture, got.capture);
            errors++;
         end
         if (got.capture_length !== want.capture_length) begin
            $display("%0t: capture_length mismatch, expected %0d actual %0d",
                     $time, want.capture_length, got.capture_length);
            errors++;
         end
         if (got.frame_length !== want.frame_length) begin
            $display("%0t: frame_length mismatch, expected %0d actual %0d",
                     $time, want.frame_length, got.frame_length);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   verdict_board board = new();
   int send_idle   = 0;
   int recv_stall  = 0;
   int cycle_count = 0;
   int bytes_sent  = 0;
   int frames_sent = 0;

   udp_port_fragment_capture_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_udp_port_fragment_capture_filter NOT OK");
         $finish;
      end
   end

   // Verdict side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // Signals are stable at the falling edge; a transaction here completes at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_verdict(rsp_payload);
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 86; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 86; end
         default: begin send_idle = 13; recv_stall = 13; end
      endcase
   endtask

   task automatic send_byte(input req_type item);
      bit taken;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      board.note_byte(item);
      bytes_sent++;
   endtask

   // Build one frame of the given kind; len_req and ihl_req override the random choice
   task automatic send_frame(input frame_kind_type kind, input int unsigned len_req = 0,
                             input int ihl_req = -1);
      logic [7:0]  tpl [128];
      logic [15:0] port;
      logic [15:0] etype;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [3:0]  ihl;
      int unsigned port_at;
      int unsigned udp_end;
      int unsigned len;
      req_type     item;
      foreach (tpl[i]) tpl[i] = 8'($urandom);
      ihl   = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom_range(15, 5));
      port  = board.port_sel;
      etype = ETHERTYPE_IPV4;
      frag  = 16'($urandom_range(3)) << 14;
      proto = UDP_PROTO;
      case (kind)
         FR_UDP_MISS: begin
            if ($urandom_range(1)) port = port ^ 16'($urandom_range(65535, 1));
            else proto = proto ^ 8'($urandom_range(255, 1));
         end
         FR_FRAGMENT: begin
            frag = 16'($urandom);
            if ((frag & FRAG_MASK) == 16'd0) frag[13] = 1'b1;
            if ($urandom_range(1)) port = 16'($urandom);
         end
         FR_NON_IPV4:  etype = ETHERTYPE_IPV4 ^ 16'($urandom_range(65535, 1));
         FR_SMALL_IHL: ihl = 4'($urandom_range(4));
         default: ;
      endcase
      if (ihl_req >= 0) ihl = 4'(ihl_req);
      port_at = PORT_BASE + 4 * ihl;
      udp_end = UDP_END_BASE + 4 * ihl;
      if (kind != FR_NOISE) begin
         tpl[12] = etype[15:8];
         tpl[13] = etype[7:0];
         tpl[14] = {tpl[14][7:4], ihl};
         tpl[20] = frag[15:8];
         tpl[21] = frag[7:0];
         tpl[23] = proto;
         tpl[port_at]     = port[15:8];
         tpl[port_at + 1] = port[7:0];
      end else if ($urandom_range(1)) begin
         tpl[12] = ETHERTYPE_IPV4[15:8];
         tpl[13] = ETHERTYPE_IPV4[7:0];
      end
      case (kind)
         FR_SHORT:     len = $urandom_range(MIN_FRAME - 1, 1);
         FR_SHORT_UDP: len = $urandom_range(udp_end - 1, MIN_FRAME);
         FR_NOISE:     len = $urandom_range(100, 1);
         default: len = ((udp_end > MIN_FRAME) ? udp_end : MIN_FRAME) + $urandom_range(12);
      endcase
      if (len_req != 0) len = len_req;
      for (int unsigned i = 0; i < len; i++) begin
         item.frame_byte = (i < 128) ? tpl[i] : 8'($urandom);
         item.last_byte  = (i == len - 1);
         send_byte(item);
      end
      frames_sent++;
   endtask

   task automatic run_frames(input int byte_budget, input int frame_floor);
      int first_byte;
      int first_frame;
      int r;
      frame_kind_type kind;
      first_byte  = bytes_sent;
      first_frame = frames_sent;
      while (bytes_sent - first_byte < byte_budget || frames_sent - first_frame < frame_floor)
      begin
         r = $urandom_range(99);
         if (r < 30)      kind = FR_UDP_HIT;
         else if (r < 45) kind = FR_UDP_MISS;
         else if (r < 60) kind = FR_FRAGMENT;
         else if (r < 68) kind = FR_NON_IPV4;
         else if (r < 76) kind = FR_SHORT;
         else if (r < 84) kind = FR_SHORT_UDP;
         else if (r < 92) kind = FR_SMALL_IHL;
         else             kind = FR_NOISE;
         send_frame(kind);
      end
   endtask

   // Hold the byte input off until every queued verdict is back, plus pipeline slack
   task automatic drain();
      req_valid <= 1'b0;
      while (board.verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      board.set_reg(idx, data);
   endtask

   task automatic configure(input logic [15:0] port, input logic [15:0] limit);
      write_csr(CSR_TARGET_PORT, port);
      write_csr(CSR_CAPTURE_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under reset settings, no idling
      set_idling(0);
      send_frame(FR_UDP_HIT, 42, 5);     // UDP header ends exactly at the frame end
      send_frame(FR_SHORT_UDP, 41, 5);   // one byte short of the UDP header
      send_frame(FR_UDP_HIT, 60, 5);
      send_frame(FR_UDP_MISS);
      send_frame(FR_FRAGMENT, 34);       // minimum length fragment
      send_frame(FR_UDP_HIT, 33, 5);     // good header but short frame
      send_frame(FR_NOISE, 1);
      send_frame(FR_NON_IPV4);
      send_frame(FR_SMALL_IHL, 0, 0);    // port read from inside the IP header
      send_frame(FR_SMALL_IHL, 0, 1);    // port overlays the fragment field
      send_frame(FR_UDP_HIT, 82, 15);
      send_frame(FR_SHORT, 13);
      drain();

      // Lowest port, smallest nonzero limit; sender pauses midway until all verdicts are in
      configure(16'd0, 16'd1);
      set_idling(1);
      run_frames(80, 2);
      drain();
      run_frames(80, 2);
      drain();

      // Highest port, largest limit
      configure(16'hFFFF, 16'd4096);
      set_idling(2);
      run_frames(140, 3);
      drain();

      // Limit zero via masked upper bits
      configure(16'($urandom), 16'hE000);
      set_idling(3);
      run_frames(140, 3);
      drain();

      // Limit above the maximum
      configure(16'($urandom), 16'hFFFF);
      set_idling(0);
      send_frame(FR_UDP_HIT, 100);
      run_frames(140, 3);
      drain();

      // Random settings; spare indexes must leave both registers alone
      write_csr(CSR_TARGET_PORT, 16'($urandom));
      write_csr(CSR_CAPTURE_LIMIT, {3'($urandom), 13'($urandom_range(4096, 1))});
      write_csr(CSR_SPARE_A, 16'($urandom));
      write_csr(CSR_SPARE_B, 16'($urandom));
      csr_valid <= 1'b0;
      set_idling(1);
      run_frames(80, 2);
      set_idling(3);
      run_frames(80, 2);
      drain();

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.verdicts.size() == 0) begin
         $display("tb_udp_port_fragment_capture_filter OK");
      end else begin
         $display("tb_udp_port_fragment_capture_filter NOT OK");
      end
      $finish;
   end

endmodule
